[src/crc_framed_actuator_command_decoder_defines.svh]
// Assertion macros for the CRC framed actuator command decoder.
// Used by modules that assert; expects clk and rst_n in scope.
`ifndef CRC_FRAMED_ACTUATOR_COMMAND_DECODER_DEFINES_SVH
`define CRC_FRAMED_ACTUATOR_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFACD_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define CFACD_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

[src/cfacd_pkg.sv]
// Package for the CRC framed actuator command decoder.
// Status codes, command opcodes, bit positions and the CRC-8 byte update.
`timescale 1ns / 1ps
`default_nettype none

package cfacd_pkg;

  localparam int MAX_PAYLOAD = 2;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_CRC_BAD   = 2'd2,
    ST_LEN_LONG  = 2'd3
  } status_t;

  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [7:0] OP_HEATER   = 8'h01;
  localparam logic [7:0] OP_COOLER   = 8'h02;
  localparam logic [7:0] OP_BOX_FAN  = 8'h03;
  localparam logic [7:0] OP_OUT_FAN  = 8'h04;
  localparam logic [7:0] OP_VENT     = 8'h05;
  localparam logic [7:0] OP_HUMID    = 8'h06;
  localparam logic [7:0] OP_VENT_WIN = 8'h07;
  localparam logic [7:0] OP_SHUTDOWN = 8'hFF;

  // actuator bit positions
  localparam int A_HEATER     = 0;
  localparam int A_COOLER     = 1;
  localparam int A_BOX_FAN    = 2;
  localparam int A_OUT_FAN    = 3;
  localparam int A_VENT_FAN   = 4;
  localparam int A_HUMIDIFIER = 5;
  localparam int A_HUMID_FAN  = 6;
  // window bit positions
  localparam int W_VENT  = 0;
  localparam int W_HUMID = 1;

  localparam logic [3:0] POS_MAX = 4'd15;

  // CRC-8/Maxim, reflected, one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/crc_framed_actuator_command_decoder.sv]
// Input register, then result register; frame and CRC logic sits in one stage between.
// Throughput: one byte per cycle while the result slot is free (empty or being taken).
// A byte may be taken while a result still waits at the output register.
// Reset (rst_n low, synchronous): frame decoder awaits a length byte, CRC and
// held bytes cleared, all actuators off, both windows closed, no result pending.
// Depends on cfacd_pkg and crc_framed_actuator_command_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "crc_framed_actuator_command_decoder_defines.svh"

module crc_framed_actuator_command_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_command,
  output logic            out_heater_on,
  output logic            out_cooler_on,
  output logic            out_box_fan_on,
  output logic            out_outside_fan_on,
  output logic            out_vent_fan_on,
  output logic            out_humidifier_on,
  output logic            out_humid_fan_on,
  output logic            out_vent_window_open,
  output logic            out_humid_window_open
);
  import cfacd_pkg::*;

  // ---------------------------------------------------------------------
  // Input register. It drains whenever the result slot is free (empty or
  // being taken this cycle), so a new byte can enter every cycle while the slot stays free.
  // ---------------------------------------------------------------------
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       advance;   // result slot can take whatever this byte produces
  logic       fire;      // registered byte is processed this cycle

  logic       out_valid_r, out_valid_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (fire) begin
      in_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Frame state
  //   pos: 0 awaiting length, else 1 + payload bytes seen (saturates)
  //   len: payload bytes still expected; 0 in a frame means CRC byte next
  // ---------------------------------------------------------------------
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] len_r, len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] val_r, val_nxt;
  logic [6:0] act_r, act_nxt;
  logic [1:0] win_r, win_nxt;

  logic       emit;      // this byte closes or rejects a frame
  status_t    status;
  logic [7:0] res_cmd;
  logic       on;

  assign on = (val_r != 8'd0);

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    crc_nxt = crc_r;
    cmd_nxt = cmd_r;
    val_nxt = val_r;
    act_nxt = act_r;
    win_nxt = win_r;
    emit    = 1'b0;
    status  = ST_APPLIED;
    res_cmd = 8'd0;

    if (fire) begin
      if (pos_r == 4'd0) begin
        // length byte opens a frame
        crc_nxt = 8'd0;
        cmd_nxt = 8'd0;
        val_nxt = 8'd0;
        if (in_byte_r > 8'(MAX_PAYLOAD)) begin
          len_nxt = 4'd0;
          emit    = 1'b1;
          status  = ST_LEN_LONG;
        end else begin
          len_nxt = in_byte_r[3:0];
          pos_nxt = 4'd1;
        end
      end else if (len_r != 4'd0) begin
        // payload byte; only the first two are kept
        if (pos_r == 4'd1) begin
          cmd_nxt = in_byte_r;
        end else if (pos_r == 4'd2) begin
          val_nxt = in_byte_r;
        end
        crc_nxt = crc8_byte(crc_r, in_byte_r);
        len_nxt = len_r - 4'd1;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 4'd1;
        end
      end else begin
        // CRC byte closes the frame
        emit    = 1'b1;
        res_cmd = cmd_r;
        if (in_byte_r != crc_r) begin
          status = ST_CRC_BAD;
        end else begin
          case (cmd_r)
            OP_HEATER:   act_nxt[A_HEATER]  = on;
            OP_COOLER:   act_nxt[A_COOLER]  = on;
            OP_BOX_FAN:  act_nxt[A_BOX_FAN] = on;
            OP_OUT_FAN:  act_nxt[A_OUT_FAN] = on;
            OP_VENT: begin
              act_nxt[A_VENT_FAN] = on;
              win_nxt[W_VENT]     = on;
            end
            OP_HUMID: begin
              act_nxt[A_HUMIDIFIER] = on;
              act_nxt[A_HUMID_FAN]  = on;
              win_nxt[W_HUMID]      = on;
            end
            OP_VENT_WIN: win_nxt[W_VENT] = on;
            OP_SHUTDOWN: begin
              act_nxt = 7'd0;
              win_nxt = 2'd0;
            end
            default: status = ST_UNKNOWN;
          endcase
        end
        pos_nxt = 4'd0;
        len_nxt = 4'd0;
        crc_nxt = 8'd0;
        cmd_nxt = 8'd0;
        val_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      len_r <= 4'd0;
      crc_r <= 8'd0;
      cmd_r <= 8'd0;
      val_r <= 8'd0;
      act_r <= 7'd0;
      win_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      cmd_r <= cmd_nxt;
      val_r <= val_nxt;
      act_r <= act_nxt;
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register. Loaded only when the slot is free (fire implies it).
  // ---------------------------------------------------------------------
  logic [1:0] res_status_r;
  logic [7:0] res_cmd_r;
  logic [6:0] res_act_r;
  logic [1:0] res_win_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_status_r <= status;
      res_cmd_r    <= res_cmd;
      res_act_r    <= act_nxt;
      res_win_r    <= win_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_status_r;
  assign out_command           = res_cmd_r;
  assign out_heater_on         = res_act_r[A_HEATER];
  assign out_cooler_on         = res_act_r[A_COOLER];
  assign out_box_fan_on        = res_act_r[A_BOX_FAN];
  assign out_outside_fan_on    = res_act_r[A_OUT_FAN];
  assign out_vent_fan_on       = res_act_r[A_VENT_FAN];
  assign out_humidifier_on     = res_act_r[A_HUMIDIFIER];
  assign out_humid_fan_on      = res_act_r[A_HUMID_FAN];
  assign out_vent_window_open  = res_win_r[W_VENT];
  assign out_humid_window_open = res_win_r[W_HUMID];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // an over-long length never carries a command
  `CFACD_ASSERT_IMP(a_len_long_no_cmd, out_valid_r && res_status_r == ST_LEN_LONG, res_cmd_r == 8'd0)
  // applied shutdown leaves everything off
  `CFACD_ASSERT_IMP(a_shutdown_clear, out_valid_r && res_status_r == ST_APPLIED && res_cmd_r == OP_SHUTDOWN, res_act_r == 7'd0 && res_win_r == 2'd0)
  // a result always returns the decoder to awaiting a length byte
  `CFACD_ASSERT_NXT(a_emit_rearm, emit, pos_r == 4'd0 && len_r == 4'd0)
  // payload count only pending inside a frame
  `CFACD_ASSERT_IMP(a_len_in_frame, len_r != 4'd0, pos_r != 4'd0)
  // a result never lands on top of one that is still waiting
  `CFACD_ASSERT_IMP(a_no_overwrite, emit, !out_valid_r || out_ready)

endmodule

`default_nettype wire

[test/crc_framed_actuator_command_decoder_tb.sv]
// Testbench for crc_framed_actuator_command_decoder: length-prefixed frames with a
// CRC-8/Maxim trailer, checked against an in-bench frame decoder and actuator predictor.
// Depends on cfacd_pkg and the decoder RTL; self-contained otherwise.
`timescale 1ns / 1ps

module crc_framed_actuator_command_decoder_tb;
  import cfacd_pkg::*;

  localparam int ITEM_TARGET  = 1350;    // rx bytes to push in total
  localparam int DRAIN_EVERY  = 300;     // bytes between full drains of the result stream
  localparam int CYCLE_LIMIT  = 400_000; // watchdog, several times the slowest legal run
  localparam int TAIL_CYCLES  = 8;       // idle tail after the final drain

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    SINK_ALWAYS = 2'd0,
    SINK_COIN   = 2'd1,
    SINK_SPARSE = 2'd2,
    SINK_LONG   = 2'd3
  } sink_mode_t;

  // one expected frame report
  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [6:0] act;   // bit positions per A_* in the package
    logic [1:0] win;   // bit positions per W_* in the package
  } frame_report_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_command;
  logic       out_heater_on;
  logic       out_cooler_on;
  logic       out_box_fan_on;
  logic       out_outside_fan_on;
  logic       out_vent_fan_on;
  logic       out_humidifier_on;
  logic       out_humid_fan_on;
  logic       out_vent_window_open;
  logic       out_humid_window_open;

  crc_framed_actuator_command_decoder uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_command           (out_command),
    .out_heater_on         (out_heater_on),
    .out_cooler_on         (out_cooler_on),
    .out_box_fan_on        (out_box_fan_on),
    .out_outside_fan_on    (out_outside_fan_on),
    .out_vent_fan_on       (out_vent_fan_on),
    .out_humidifier_on     (out_humidifier_on),
    .out_humid_fan_on      (out_humid_fan_on),
    .out_vent_window_open  (out_vent_window_open),
    .out_humid_window_open (out_humid_window_open)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the frame decoder and the actuator registers.
  // ---------------------------------------------------------------------------
  logic [3:0] frame_pos   = 4'd0;  // 0 = waiting for a length byte
  logic [3:0] bytes_left  = 4'd0;  // payload bytes still to come
  logic [7:0] running_crc = 8'h00;
  logic [7:0] held_cmd    = 8'h00;
  logic [7:0] held_val    = 8'h00;
  logic [6:0] actuators   = 7'd0;
  logic [1:0] windows     = 2'd0;

  frame_report_t pending_reports[$];

  int mismatches  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;

  // sender pacing
  bit pacing_on  = 1'b1;
  int burst_left = 4;

  // receiver pattern
  sink_mode_t sink_mode  = SINK_ALWAYS;
  int         mode_left  = 32;
  int         stall_left = 0;

  logic [7:0] known_ops [8] = '{OP_HEATER, OP_COOLER, OP_BOX_FAN, OP_OUT_FAN,
                                OP_VENT, OP_HUMID, OP_VENT_WIN, OP_SHUTDOWN};

  // CRC-8/Maxim: reflected, shift right, xor the poly when the dropped bit differs
  function automatic logic [7:0] crc8_maxim_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] d;
    r = acc;
    d = b;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ d[0]) ? ({1'b0, r[7:1]} ^ CRC_POLY) : {1'b0, r[7:1]};
      d = {1'b0, d[7:1]};
    end
    return r;
  endfunction

  // Applies the held command to the actuator copy; returns the report status.
  function automatic status_t apply_actuator_command();
    logic on;
    on = (held_val != 8'h00);
    case (held_cmd)
      OP_HEATER:   actuators[A_HEATER]  = on;
      OP_COOLER:   actuators[A_COOLER]  = on;
      OP_BOX_FAN:  actuators[A_BOX_FAN] = on;
      OP_OUT_FAN:  actuators[A_OUT_FAN] = on;
      OP_VENT: begin
        actuators[A_VENT_FAN] = on;
        windows[W_VENT]       = on;
      end
      OP_HUMID: begin
        actuators[A_HUMIDIFIER] = on;
        actuators[A_HUMID_FAN]  = on;
        windows[W_HUMID]        = on;
      end
      OP_VENT_WIN: windows[W_VENT] = on;
      OP_SHUTDOWN: begin
        actuators = 7'd0;
        windows   = 2'd0;
      end
      default: return ST_UNKNOWN;
    endcase
    return ST_APPLIED;
  endfunction

  function automatic void queue_report(input status_t st, input logic [7:0] cmd);
    frame_report_t r;
    r.status  = st;
    r.command = cmd;
    r.act     = actuators;
    r.win     = windows;
    pending_reports.push_back(r);
  endfunction

  // Advances the decoder copy by one accepted rx byte.
  function automatic void decode_rx_byte(input logic [7:0] b);
    status_t st;
    if (frame_pos == 4'd0) begin
      running_crc = 8'h00;
      held_cmd    = 8'h00;
      held_val    = 8'h00;
      if (b > MAX_PAYLOAD) begin
        // over-long length: reported at once, next byte is a new length
        bytes_left = 4'd0;
        queue_report(ST_LEN_LONG, 8'h00);
      end else begin
        bytes_left = b[3:0];
        frame_pos  = 4'd1;
      end
    end else if (bytes_left != 4'd0) begin
      if (frame_pos == 4'd1) begin
        held_cmd = b;
      end else if (frame_pos == 4'd2) begin
        held_val = b;
      end
      running_crc = crc8_maxim_step(running_crc, b);
      bytes_left  = bytes_left - 4'd1;
      if (frame_pos < POS_MAX) begin
        frame_pos = frame_pos + 4'd1;
      end
    end else begin
      // trailer byte closes the frame
      st = (b == running_crc) ? apply_actuator_command() : ST_CRC_BAD;
      queue_report(st, held_cmd);
      frame_pos   = 4'd0;
      bytes_left  = 4'd0;
      running_crc = 8'h00;
      held_cmd    = 8'h00;
      held_val    = 8'h00;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per call, held until the transfer, then maybe a gap.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_rx_byte(b);
    bytes_sent++;
    if (pacing_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      end
    end
  endtask

  // Full frame: length n (0..2), payload, trailer; corrupt flips trailer bits.
  task automatic send_frame(input int n, input logic [7:0] op, input logic [7:0] val,
                            input bit corrupt);
    logic [7:0] body [2];
    logic [7:0] crc;
    body[0] = op;
    body[1] = val;
    crc     = 8'h00;
    send_byte(n[7:0]);
    for (int k = 0; k < n; k++) begin
      send_byte(body[k]);
      crc = crc8_maxim_step(crc, body[k]);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(crc);
  endtask

  // Sender holds off until every queued report has been seen.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Length byte handling: over-long lengths and the empty frame.
  task automatic test_length_field();
    send_byte(8'(MAX_PAYLOAD + 1));  // just over the limit
    send_byte(8'hFF);                // all ones
    send_byte(8'h10);                // low nibble zero, still too long
    send_frame(0, 8'h00, 8'h00, 1'b0);  // empty frame, good trailer -> unknown cmd 0
    send_frame(0, 8'h00, 8'h00, 1'b1);  // empty frame, bad trailer
  endtask

  // Every opcode, plus missing value byte, unknown opcode and a bad trailer.
  task automatic test_each_command();
    send_frame(2, OP_HEATER,   8'hFF, 1'b0);
    send_frame(2, OP_COOLER,   8'h01, 1'b0);
    send_frame(2, OP_BOX_FAN,  8'h80, 1'b0);
    send_frame(2, OP_OUT_FAN,  8'h7F, 1'b0);
    send_frame(2, OP_VENT,     8'h55, 1'b0);
    send_frame(2, OP_HUMID,    8'hAA, 1'b1);  // trailer wrong: nothing changes
    send_frame(2, OP_HUMID,    8'hAA, 1'b0);
    send_frame(1, OP_VENT_WIN, 8'h00, 1'b0);  // no value byte: window closes
    send_frame(2, 8'h08,       8'h01, 1'b0);  // unknown opcode
    send_frame(1, OP_SHUTDOWN, 8'h00, 1'b0);
  endtask

  // Mostly well-formed frames with random content; the rest is line noise
  // followed by filler until the decoder is back at a frame boundary.
  task automatic test_random_traffic();
    int         pick;
    int         n;
    int         next_drain;
    logic [7:0] op;
    logic [7:0] val;
    next_drain = bytes_sent + DRAIN_EVERY;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= next_drain) begin
        wait_for_drain();
        next_drain += DRAIN_EVERY;
        pacing_on = !pacing_on;  // alternate gapped and back-to-back stretches
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        n   = (pick < 60) ? 2 : $urandom_range(0, 1);
        op  = ($urandom_range(0, 9) < 8) ? known_ops[$urandom_range(0, 7)]
                                         : 8'($urandom_range(0, 255));
        val = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        send_frame(n, op, val, $urandom_range(0, 9) == 0);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        while (frame_pos != 4'd0) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switches between back-pressure patterns at random intervals.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(16, 96);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (sink_mode)
      SINK_ALWAYS: out_ready <= 1'b1;
      SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: out_ready <= (cycle_count[1:0] == 2'b00);
      default: begin
        if (stall_left == 0) begin
          out_ready  <= 1'b1;
          stall_left <= $urandom_range(1, 24);
        end else begin
          out_ready  <= 1'b0;
          stall_left <= stall_left - 1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer on the out channel pops one expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_report_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d command %0d",
                 $time, out_status, out_command);
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        check_field("status",            int'(e.status),         out_status);
        check_field("command",           e.command,              out_command);
        check_field("heater_on",         e.act[A_HEATER],        out_heater_on);
        check_field("cooler_on",         e.act[A_COOLER],        out_cooler_on);
        check_field("box_fan_on",        e.act[A_BOX_FAN],       out_box_fan_on);
        check_field("outside_fan_on",    e.act[A_OUT_FAN],       out_outside_fan_on);
        check_field("vent_fan_on",       e.act[A_VENT_FAN],      out_vent_fan_on);
        check_field("humidifier_on",     e.act[A_HUMIDIFIER],    out_humidifier_on);
        check_field("humid_fan_on",      e.act[A_HUMID_FAN],     out_humid_fan_on);
        check_field("vent_window_open",  e.win[W_VENT],          out_vent_window_open);
        check_field("humid_window_open", e.win[W_HUMID],         out_humid_window_open);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, pending_reports.size());
      $display("[crc_framed_actuator_command_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests, random traffic, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_length_field();
    test_each_command();
    test_random_traffic();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);  // catch stray extra results
    if (mismatches == 0) begin
      $display("[crc_framed_actuator_command_decoder] OK");
    end else begin
      $display("[crc_framed_actuator_command_decoder] ERROR");
    end
    $finish;
  end

endmodule
